/* sv/dmhtq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmhtq_pkg
// Shared sizes, entry layout, status codes and sequencer states of the
// deadline min-heap timer queue.
// ---------------------------------------------------------------------------
package dmhtq_pkg;

	localparam int HEAP_CAPACITY = 64;
	localparam int DEADLINE_BITS = 64;
	localparam int ID_BITS       = 6;
	localparam int ID_COUNT      = 1 << ID_BITS;
	localparam int TIME_BITS     = 64;
	localparam int ADDR_W        = $clog2(HEAP_CAPACITY);
	localparam int CNT_W         = $clog2(HEAP_CAPACITY + 1);
	localparam int CHILD_W       = ADDR_W + 2;
	localparam int STATUS_W      = 3;

	localparam logic [STATUS_W-1:0] STAT_INSERTED    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_RESCHEDULED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_EXPIRED     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE        = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd4;

	localparam logic KIND_SCHEDULE = 1'b0;
	localparam logic KIND_POLL     = 1'b1;

	typedef struct packed {
		logic [ID_BITS-1:0]       id;
		logic [DEADLINE_BITS-1:0] dl;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_POLL_CHK,
		S_POP_GET,
		S_DN_START,
		S_DN_RL,
		S_DN_RR,
		S_DN_LAST,
		S_UP_START,
		S_UP_CHK,
		S_PLACE,
		S_DONE
	} state_t;

endpackage

/* sv/dmhtq_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmhtq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module dmhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/deadline_min_heap_timer_queue_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_min_heap_timer_queue_core
// Timer queue kept as a binary min-heap of (id, deadline) in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: kind 0 schedules entry_id at deadline time_value (insert, or
//   move an already queued id); kind 1 polls with time_value as now and pops
//   the earliest entry if its deadline is at or before now.
//   Output beat: status, result_id, result_deadline and occupancy after the
//   operation. Every input beat gives exactly one output beat.
//   One item is worked at a time; in_stall is high from acceptance until
//   the result is moved into the output register. Each heap access is a
//   read of the heap RAM with registered read data: a reschedule scans
//   the queued entries one by one (S_SRCH_RD, S_SRCH_CHK), sift-up works
//   level by level (S_UP_START, S_UP_CHK) and sift-down or the pop walk
//   works level by level (S_DN_START, S_DN_RL, S_DN_RR).
//   The output register holds the result while out_stall is high; a
//   finished item waits in its last state, with the input stalled, until
//   the register is free.
//   Reset empties the queue at once; heap RAM contents need no clearing.
// ---------------------------------------------------------------------------
module deadline_min_heap_timer_queue_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [dmhtq_pkg::ID_BITS-1:0]       entry_id,
	input  logic [dmhtq_pkg::TIME_BITS-1:0]     time_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dmhtq_pkg::STATUS_W-1:0]      status,
	output logic [dmhtq_pkg::ID_BITS-1:0]       result_id,
	output logic [dmhtq_pkg::TIME_BITS-1:0]     result_deadline,
	output logic [dmhtq_pkg::CNT_W-1:0]         occupancy
);
	import dmhtq_pkg::*;

	state_t state_q, state_d;
	logic [ADDR_W-1:0]   pos_q, pos_d;
	entry_t              cur_q, cur_d;
	entry_t              lq_q, lq_d;
	logic                walk_q, walk_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [ID_COUNT-1:0] queued_q;
	logic                flag_set, flag_clr;
	logic [ID_BITS-1:0]  flag_idx;

	logic [STATUS_W-1:0]      res_status_q, res_status_d;
	logic [ID_BITS-1:0]       res_id_q, res_id_d;
	logic [DEADLINE_BITS-1:0] res_dl_q, res_dl_d;

	logic                     out_valid_q, out_valid_d, out_load;
	logic [STATUS_W-1:0]      out_status_q;
	logic [ID_BITS-1:0]       out_id_q;
	logic [DEADLINE_BITS-1:0] out_dl_q;
	logic [CNT_W-1:0]         out_occ_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	logic [CHILD_W-1:0] l_w, r_w, size_w;
	logic [ADDR_W-1:0]  parent_w;
	logic               in_acc;

	dmhtq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HEAP_CAPACITY)
	) u_heap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rbits)
	);

	assign ram_rdata = entry_t'(ram_rbits);
	assign l_w       = {1'b0, pos_q, 1'b1};
	assign r_w       = l_w + CHILD_W'(1);
	assign size_w    = CHILD_W'(count_q);
	assign parent_w  = (pos_q - ADDR_W'(1)) >> 1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;

	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		cur_d        = cur_q;
		lq_d         = lq_q;
		walk_d       = walk_q;
		count_d      = count_q;
		res_status_d = res_status_q;
		res_id_d     = res_id_q;
		res_dl_d     = res_dl_q;
		flag_set     = 1'b0;
		flag_clr     = 1'b0;
		flag_idx     = cur_q.id;
		ram_we       = 1'b0;
		ram_waddr    = pos_q;
		ram_wdata    = cur_q;
		ram_raddr    = pos_q;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cur_d.id = entry_id;
					cur_d.dl = time_value[DEADLINE_BITS-1:0];
					if (kind == KIND_POLL) begin
						ram_raddr = '0;
						state_d   = S_POLL_CHK;
					end else begin
						res_id_d = entry_id;
						res_dl_d = time_value[DEADLINE_BITS-1:0];
						if (queued_q[entry_id]) begin
							res_status_d = STAT_RESCHEDULED;
							pos_d        = '0;
							state_d      = S_SRCH_RD;
						end else if (count_q == CNT_W'(HEAP_CAPACITY)) begin
							res_status_d = STAT_FULL;
							state_d      = S_DONE;
						end else begin
							res_status_d = STAT_INSERTED;
							count_d      = count_q + CNT_W'(1);
							flag_set     = 1'b1;
							flag_idx     = entry_id;
							pos_d        = count_q[ADDR_W-1:0];
							state_d      = S_UP_START;
						end
					end
				end
			end
			S_SRCH_RD: begin
				ram_raddr = pos_q;
				state_d   = S_SRCH_CHK;
			end
			S_SRCH_CHK: begin
				if (ram_rdata.id == cur_q.id) begin
					walk_d  = 1'b0;
					state_d = (ram_rdata.dl < cur_q.dl) ? S_DN_START : S_UP_START;
				end else if (CNT_W'(pos_q) + CNT_W'(1) < count_q) begin
					pos_d   = pos_q + ADDR_W'(1);
					state_d = S_SRCH_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POLL_CHK: begin
				if (count_q != '0 && ram_rdata.dl <= cur_q.dl) begin
					res_status_d = STAT_EXPIRED;
					res_id_d     = ram_rdata.id;
					res_dl_d     = ram_rdata.dl;
					flag_clr     = 1'b1;
					flag_idx     = ram_rdata.id;
					count_d      = count_q - CNT_W'(1);
					ram_raddr    = count_d[ADDR_W-1:0];
					state_d      = (count_q == CNT_W'(1)) ? S_DONE : S_POP_GET;
				end else begin
					res_status_d = STAT_NONE;
					res_id_d     = '0;
					res_dl_d     = '0;
					state_d      = S_DONE;
				end
			end
			S_POP_GET: begin
				// last entry refills the tree after the hole walks to a leaf
				cur_d   = ram_rdata;
				pos_d   = '0;
				walk_d  = 1'b1;
				state_d = S_DN_START;
			end
			S_DN_START: begin
				ram_raddr = l_w[ADDR_W-1:0];
				if (r_w < size_w) begin
					state_d = S_DN_RL;
				end else if (r_w == size_w) begin
					state_d = S_DN_LAST;
				end else if (walk_q) begin
					state_d = S_UP_START;
				end else begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_RL: begin
				lq_d      = ram_rdata;
				ram_raddr = r_w[ADDR_W-1:0];
				state_d   = S_DN_RR;
			end
			S_DN_RR: begin
				ram_we = 1'b1;
				if (walk_q || lq_q.dl < cur_q.dl) begin
					if (lq_q.dl <= ram_rdata.dl) begin
						ram_wdata = lq_q;
						pos_d     = l_w[ADDR_W-1:0];
					end else begin
						ram_wdata = ram_rdata;
						pos_d     = r_w[ADDR_W-1:0];
					end
					state_d = S_DN_START;
				end else if (cur_q.dl <= ram_rdata.dl) begin
					ram_wdata = cur_q;
					state_d   = S_DONE;
				end else begin
					ram_wdata = ram_rdata;
					pos_d     = r_w[ADDR_W-1:0];
					state_d   = S_DN_START;
				end
			end
			S_DN_LAST: begin
				ram_we = 1'b1;
				if (walk_q || ram_rdata.dl < cur_q.dl) begin
					ram_wdata = ram_rdata;
					pos_d     = l_w[ADDR_W-1:0];
					state_d   = walk_q ? S_UP_START : S_PLACE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_UP_START: begin
				ram_raddr = parent_w;
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				ram_we = 1'b1;
				if (ram_rdata.dl <= cur_q.dl) begin
					state_d = S_DONE;
				end else begin
					ram_wdata = ram_rdata;
					pos_d     = parent_w;
					state_d   = S_UP_START;
				end
			end
			S_PLACE: begin
				ram_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			queued_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			if (flag_set) begin
				queued_q[flag_idx] <= 1'b1;
			end
			if (flag_clr) begin
				queued_q[flag_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		cur_q        <= cur_d;
		lq_q         <= lq_d;
		walk_q       <= walk_d;
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		res_dl_q     <= res_dl_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_dl_q     <= res_dl_q;
			out_occ_q    <= count_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign result_id       = out_id_q;
	assign result_deadline = TIME_BITS'(out_dl_q);
	assign occupancy       = out_occ_q;

endmodule
